// ===== design/cbfp_pkg.sv =====
// Shared types and constants of the camera block frame parser.
`timescale 1ns / 1ps

package cbfp_pkg;

   localparam logic [15:0] NO_WORD     = 16'hFFFF;
   localparam logic [9:0]  ARRAY_LIMIT = 10'd1000;
   localparam logic [2:0]  BASE_FIELDS = 3'd5;

   localparam logic [15:0] RESET_START_WORD    = 16'd43605;
   localparam logic [15:0] RESET_START_WORD_CC = 16'd43606;
   localparam logic [9:0]  RESET_MAX_BLOCKS    = 10'd100;
   localparam logic [7:0]  RESET_HUNT_LIMIT    = 8'd30;

   localparam logic [1:0] REG_START_WORD    = 2'd0;
   localparam logic [1:0] REG_START_WORD_CC = 2'd1;
   localparam logic [1:0] REG_MAX_BLOCKS    = 2'd2;
   localparam logic [1:0] REG_HUNT_LIMIT    = 2'd3;

   localparam logic [1:0] KIND_BLOCK     = 2'd0;
   localparam logic [1:0] KIND_FRAME_END = 2'd1;
   localparam logic [1:0] KIND_NO_START  = 2'd2;
   localparam logic [1:0] KIND_NO_DATA   = 2'd3;

   typedef struct packed {
      logic [15:0] start_word;
      logic [15:0] start_word_cc;
      logic [9:0]  max_blocks;
      logic [7:0]  hunt_limit;
   } cfg_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [15:0]        signature;
      logic [15:0]        pos_x;
      logic [15:0]        pos_y;
      logic [15:0]        box_width;
      logic [15:0]        box_height;
      logic signed [15:0] angle;
      logic               sum_ok;
      logic               is_color_code;
      logic [9:0]         good_count;
   } result_type;

endpackage

// ===== design/cbfp_csr.sv =====
// Configuration register file with an APB-style access port.
`timescale 1ns / 1ps

module cbfp_csr
   import cbfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output cfg_type     cfg
);

   cfg_type cfg_ff;
   logic    write_en;

   assign pready   = 1'b1;
   assign write_en = psel && penable && pwrite && pready;
   assign cfg      = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_word    <= RESET_START_WORD;
         cfg_ff.start_word_cc <= RESET_START_WORD_CC;
         cfg_ff.max_blocks    <= RESET_MAX_BLOCKS;
         cfg_ff.hunt_limit    <= RESET_HUNT_LIMIT;
      end else if (write_en) begin
         unique case (paddr[3:2])
            REG_START_WORD:    cfg_ff.start_word    <= pwdata[15:0];
            REG_START_WORD_CC: cfg_ff.start_word_cc <= pwdata[15:0];
            REG_MAX_BLOCKS:    cfg_ff.max_blocks    <= pwdata[9:0];
            REG_HUNT_LIMIT:    cfg_ff.hunt_limit    <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_START_WORD:    prdata = {16'd0, cfg_ff.start_word};
         REG_START_WORD_CC: prdata = {16'd0, cfg_ff.start_word_cc};
         REG_MAX_BLOCKS:    prdata = {22'd0, cfg_ff.max_blocks};
         REG_HUNT_LIMIT:    prdata = {24'd0, cfg_ff.hunt_limit};
         default:           prdata = 32'd0;
      endcase
   end

endmodule

// ===== design/cbfp_core.sv =====
// Input word register and the frame parsing state machine.
`timescale 1ns / 1ps

module cbfp_core
   import cbfp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       in_valid,
   input  logic [15:0] in_word,
   output logic       in_ready,
   input  logic       res_space,
   output logic       res_valid,
   output result_type res_data
);

   typedef enum logic [1:0] {PH_HUNT, PH_CSUM, PH_FIELDS, PH_SYNC} phase_type;

   logic        in_valid_ff;
   logic [15:0] in_word_ff;

   phase_type   phase_ff, phase_in;
   logic [15:0] previous_word_ff, previous_word_in;
   logic [7:0]  hunt_count_ff, hunt_count_in;
   logic        cc_mode_ff, cc_mode_in;
   logic [2:0]  field_index_ff, field_index_in;
   logic [15:0] running_sum_ff, running_sum_in;
   logic [15:0] expected_sum_ff, expected_sum_in;
   logic [9:0]  block_count_ff, block_count_in;
   logic [15:0] field_store_ff [BASE_FIELDS];

   logic        advance;
   logic        emit;
   logic        store_en;
   logic [9:0]  limit;
   logic        is_start;
   logic        is_start_cc;
   logic        cc_of_word;
   logic [15:0] sum_next;
   logic [7:0]  hunt_next;
   logic [2:0]  need;
   logic        ok;
   logic [15:0] w;

   assign advance  = in_valid_ff && res_space;
   assign in_ready = !in_valid_ff || res_space;
   assign w        = in_word_ff;

   assign limit       = (cfg.max_blocks > ARRAY_LIMIT) ? ARRAY_LIMIT : cfg.max_blocks;
   assign is_start    = (w == cfg.start_word);
   assign is_start_cc = (w == cfg.start_word_cc);
   assign cc_of_word  = !is_start;
   assign sum_next    = running_sum_ff + w;
   assign hunt_next   = hunt_count_ff + 8'd1;
   assign need        = BASE_FIELDS + {2'd0, cc_mode_ff};
   assign ok          = (sum_next == expected_sum_ff);

   always_comb begin
      phase_in         = phase_ff;
      previous_word_in = previous_word_ff;
      hunt_count_in    = hunt_count_ff;
      cc_mode_in       = cc_mode_ff;
      field_index_in   = field_index_ff;
      running_sum_in   = running_sum_ff;
      expected_sum_in  = expected_sum_ff;
      block_count_in   = block_count_ff;
      store_en         = 1'b0;
      emit             = 1'b0;
      res_data         = '0;

      unique case (phase_ff)
         PH_CSUM: begin
            if (block_count_ff >= limit || (!is_start && !is_start_cc && w == 16'd0)) begin
               emit                = 1'b1;
               res_data.kind       = KIND_FRAME_END;
               res_data.good_count = block_count_ff;
               phase_in            = PH_HUNT;
               previous_word_in    = NO_WORD;
               hunt_count_in       = 8'd0;
            end else if (is_start || is_start_cc) begin
               emit                = 1'b1;
               res_data.kind       = KIND_FRAME_END;
               res_data.good_count = block_count_ff;
               cc_mode_in          = cc_of_word;
               block_count_in      = 10'd0;
            end else begin
               expected_sum_in = w;
               running_sum_in  = 16'd0;
               field_index_in  = 3'd0;
               phase_in        = PH_FIELDS;
            end
         end
         PH_FIELDS: begin
            running_sum_in = sum_next;
            store_en       = (field_index_ff < BASE_FIELDS);
            field_index_in = field_index_ff + 3'd1;
            if (field_index_in >= need) begin
               if (ok && block_count_ff < ARRAY_LIMIT) begin
                  block_count_in = block_count_ff + 10'd1;
               end
               emit                   = 1'b1;
               res_data.kind          = KIND_BLOCK;
               res_data.signature     = field_store_ff[0];
               res_data.pos_x         = field_store_ff[1];
               res_data.pos_y         = field_store_ff[2];
               res_data.box_width     = field_store_ff[3];
               res_data.box_height    = cc_mode_ff ? field_store_ff[4] : w;
               res_data.angle         = cc_mode_ff ? w : 16'sd0;
               res_data.sum_ok        = ok;
               res_data.is_color_code = cc_mode_ff;
               res_data.good_count    = block_count_in;
               field_index_in         = 3'd0;
               phase_in               = PH_SYNC;
            end
         end
         PH_SYNC: begin
            if (is_start || is_start_cc) begin
               cc_mode_in = cc_of_word;
            end
            if ((is_start || is_start_cc) && block_count_ff < limit) begin
               phase_in = PH_CSUM;
            end else begin
               emit                = 1'b1;
               res_data.kind       = KIND_FRAME_END;
               res_data.good_count = block_count_ff;
               phase_in            = PH_HUNT;
               previous_word_in    = NO_WORD;
               hunt_count_in       = 8'd0;
            end
         end
         default: begin
            hunt_count_in = hunt_next;
            if (w == 16'd0 && previous_word_ff == 16'd0) begin
               emit             = 1'b1;
               res_data.kind    = KIND_NO_DATA;
               previous_word_in = NO_WORD;
               hunt_count_in    = 8'd0;
            end else if (previous_word_ff == cfg.start_word && (is_start || is_start_cc)) begin
               cc_mode_in     = cc_of_word;
               block_count_in = 10'd0;
               phase_in       = PH_CSUM;
            end else if (hunt_next >= cfg.hunt_limit) begin
               emit             = 1'b1;
               res_data.kind    = KIND_NO_START;
               previous_word_in = NO_WORD;
               hunt_count_in    = 8'd0;
            end else begin
               previous_word_in = w;
            end
         end
      endcase
   end

   assign res_valid = advance && emit;

   always_ff @(posedge clock) begin
      if (in_ready) begin
         in_word_ff <= in_word;
      end
      if (advance) begin
         expected_sum_ff <= expected_sum_in;
         running_sum_ff  <= running_sum_in;
         if (store_en) begin
            field_store_ff[field_index_ff] <= w;
         end
      end
      if (reset) begin
         in_valid_ff      <= 1'b0;
         phase_ff         <= PH_HUNT;
         previous_word_ff <= NO_WORD;
         hunt_count_ff    <= 8'd0;
         cc_mode_ff       <= 1'b0;
         field_index_ff   <= 3'd0;
         block_count_ff   <= 10'd0;
      end else begin
         if (in_ready) begin
            in_valid_ff <= in_valid;
         end
         if (advance) begin
            phase_ff         <= phase_in;
            previous_word_ff <= previous_word_in;
            hunt_count_ff    <= hunt_count_in;
            cc_mode_ff       <= cc_mode_in;
            field_index_ff   <= field_index_in;
            block_count_ff   <= block_count_in;
         end
      end
   end

endmodule

// ===== design/cbfp_out_buf.sv =====
// Two-entry result buffer that decouples the parser from the result channel.
`timescale 1ns / 1ps

module cbfp_out_buf
   import cbfp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   output logic       space,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   result_type entry_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic       pop;

   assign space     = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign pop       = out_valid && out_ready;
   assign out_data  = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

// ===== design/camera_block_frame_parser.sv =====
// Top level of the camera block frame parser.
// Each word is registered at the input; its result then goes to the result buffer.
// Throughput: one word per cycle while the result buffer has space.
// A two-entry result buffer absorbs result stalls; once it is full every word waits.
// Reset (synchronous, active high) restores the registers to their defaults,
// empties the pipeline and puts the parser back into the hunt for a start pair.
`timescale 1ns / 1ps

module camera_block_frame_parser
   import cbfp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [15:0]  req_tdata,   // word
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // signature, pos_x, pos_y, box_width, box_height, angle, sum_ok, good_count
   output logic [111:0] rsp_tdata,
   output logic [2:0]   rsp_tuser,   // kind, is_color_code
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   cfg_type    cfg;
   logic       res_space;
   logic       res_valid;
   result_type res_data;
   result_type out_data;

   cbfp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   cbfp_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_tvalid),
      .in_word   (req_tdata),
      .in_ready  (req_tready),
      .res_space (res_space),
      .res_valid (res_valid),
      .res_data  (res_data)
   );

   cbfp_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res_data),
      .space     (res_space),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data)
   );

   assign rsp_tdata = {5'd0, out_data.good_count, out_data.sum_ok, out_data.angle,
                       out_data.box_height, out_data.box_width, out_data.pos_y,
                       out_data.pos_x, out_data.signature};
   assign rsp_tuser = {out_data.is_color_code, out_data.kind};

endmodule
